/* hw/rtl/biv_pkg.sv */
// shared types and constants for the boot image verifier
package biv_pkg;

  localparam int unsigned SIZE_W = 25;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam int unsigned MAX_IMAGE_BYTES_DEF = 16777216;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_EXPECTED_SIZE  = 3'd0,
    REG_EXPECTED_CRC   = 3'd1,
    REG_PARTITION_SIZE = 3'd2,
    REG_EXEC_BASE      = 3'd3,
    REG_SRAM_LOW       = 3'd4,
    REG_SRAM_HIGH      = 3'd5
  } reg_idx_t;

  // window settings seen by the vector check
  typedef struct packed {
    logic [SIZE_W-1:0] partition_size;
    logic [WORD_W-1:0] exec_base;
    logic [WORD_W-1:0] sram_low;
    logic [WORD_W-1:0] sram_high;
  } window_cfg_t;

endpackage

/* hw/rtl/biv_in_if.sv */
// input channel: one image byte per request
interface biv_in_if import biv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

/* hw/rtl/biv_out_if.sv */
// output channel: one verdict per request
interface biv_out_if import biv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              size_ok;
  logic              vector_ok;
  logic              crc_ok;
  logic              image_ok;
  logic [WORD_W-1:0] computed_crc;

  modport source (output valid, output size_ok, output vector_ok, output crc_ok,
                  output image_ok, output computed_crc, input ready);
  modport sink (input valid, input size_ok, input vector_ok, input crc_ok,
                input image_ok, input computed_crc, output ready);
endinterface

/* hw/rtl/biv_vector_check.sv */
// stack pointer and reset vector window check
module biv_vector_check import biv_pkg::*; (
  input  logic [WORD_W-1:0] stack_word,
  input  logic [WORD_W-1:0] entry_word,
  input  window_cfg_t       win,
  output logic              ok
);

  logic [WORD_W-1:0] target;
  logic [WORD_W:0]   top;
  logic              stack_in;
  logic              entry_in;

  assign target = {entry_word[WORD_W-1:1], 1'b0};
  // window end carries one extra bit, so it never wraps
  assign top    = {1'b0, win.exec_base} + {{(WORD_W+1-SIZE_W){1'b0}}, win.partition_size};

  assign stack_in = (stack_word >= win.sram_low) && (stack_word <= win.sram_high);
  assign entry_in = entry_word[0] && (target >= win.exec_base) && ({1'b0, target} < top);
  assign ok       = stack_in && entry_in;

endmodule

/* hw/rtl/boot_image_verifier.sv */
// top level of the boot image verifier
//
//  channel   dir  payload                                        moves
//  item      in   data_byte[7:0], first_byte                     one image byte
//  verdict   out  size_ok, vector_ok, crc_ok, image_ok, crc[31:0] one verdict
//  cfg       in   cfg_we, cfg_index[2:0], cfg_data[31:0]         register write
//
// one byte per cycle unless stalled; the crc, byte count and word capture
// update as an open image's byte is taken, and its last byte's verdict
// appears in the output register on the next cycle. item.ready drops only
// while a verdict waits and the verdict side is stalled. rst restores register
// defaults and idles the checker until a byte with first_byte set arrives.
module boot_image_verifier import biv_pkg::*; #(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  biv_in_if.sink            item,
  biv_out_if.source         verdict
);

  localparam int unsigned MAXW = 29;
  localparam logic [MAXW-1:0] MaxBytes = MAXW'(MAX_IMAGE_BYTES);

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // configuration registers
  logic [SIZE_W-1:0] expected_size;
  logic [WORD_W-1:0] expected_crc;
  window_cfg_t       win;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size      <= '0;
      expected_crc       <= '0;
      win.partition_size <= SIZE_W'(65536);
      win.exec_base      <= 32'h08000000;
      win.sram_low       <= 32'h20000000;
      win.sram_high      <= 32'h20010000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EXPECTED_SIZE:  expected_size      <= cfg_data[SIZE_W-1:0];
        REG_EXPECTED_CRC:   expected_crc       <= cfg_data;
        REG_PARTITION_SIZE: win.partition_size <= cfg_data[SIZE_W-1:0];
        REG_EXEC_BASE:      win.exec_base      <= cfg_data;
        REG_SRAM_LOW:       win.sram_low       <= cfg_data;
        REG_SRAM_HIGH:      win.sram_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  // running state
  logic [WORD_W-1:0] crc_accum,  crc_accum_next;
  logic [SIZE_W-1:0] bytes_seen, bytes_seen_next;
  logic [WORD_W-1:0] stack_word, stack_word_next;
  logic [WORD_W-1:0] entry_word, entry_word_next;
  logic              verdict_given, verdict_given_next;

  logic              take;
  logic              active;
  logic [SIZE_W-1:0] pos;
  logic [WORD_W-1:0] crc_base;
  logic [WORD_W-1:0] stack_base;
  logic [WORD_W-1:0] entry_base;
  logic              size_ok;
  logic              emit;
  logic              window_ok;
  logic [WORD_W-1:0] final_crc;

  // output register
  logic              out_valid;
  logic              out_size_ok;
  logic              out_vector_ok;
  logic              out_crc_ok;
  logic              out_image_ok;
  logic [WORD_W-1:0] out_crc;

  assign item.ready = !out_valid || verdict.ready;
  assign take       = item.valid && item.ready;
  assign active     = item.first_byte || !verdict_given;

  assign size_ok = (expected_size != '0) && (expected_size <= win.partition_size) &&
                   ({{(MAXW-SIZE_W){1'b0}}, expected_size} <= MaxBytes);

  always_comb begin
    pos        = item.first_byte ? '0 : bytes_seen;
    crc_base   = item.first_byte ? CRC_INIT : crc_accum;
    stack_base = item.first_byte ? '0 : stack_word;
    entry_base = item.first_byte ? '0 : entry_word;

    crc_accum_next  = crc_byte(crc_base, item.data_byte);
    bytes_seen_next = pos + SIZE_W'(1);
    stack_word_next = stack_base;
    entry_word_next = entry_base;
    if (pos < SIZE_W'(4)) begin
      stack_word_next = stack_base | (WORD_W'(item.data_byte) << {pos[1:0], 3'b000});
    end else if (pos < SIZE_W'(8)) begin
      entry_word_next = entry_base | (WORD_W'(item.data_byte) << {pos[1:0], 3'b000});
    end

    emit               = !(size_ok && (bytes_seen_next < expected_size));
    verdict_given_next = emit;
    final_crc          = ~crc_accum_next;
  end

  biv_vector_check u_vector (
    .stack_word (stack_word_next),
    .entry_word (entry_word_next),
    .win        (win),
    .ok         (window_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum     <= CRC_INIT;
      bytes_seen    <= '0;
      stack_word    <= '0;
      entry_word    <= '0;
      verdict_given <= 1'b1;
    end else if (take && active) begin
      crc_accum     <= crc_accum_next;
      bytes_seen    <= bytes_seen_next;
      stack_word    <= stack_word_next;
      entry_word    <= entry_word_next;
      verdict_given <= verdict_given_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item.ready) begin
      out_valid <= take && active && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active && emit) begin
      out_size_ok   <= size_ok;
      out_vector_ok <= window_ok && (bytes_seen_next >= SIZE_W'(8));
      out_crc_ok    <= size_ok && (final_crc == expected_crc);
      out_image_ok  <= size_ok && window_ok && (bytes_seen_next >= SIZE_W'(8)) &&
                       (final_crc == expected_crc);
      out_crc       <= final_crc;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.size_ok      = out_size_ok;
  assign verdict.vector_ok    = out_vector_ok;
  assign verdict.crc_ok       = out_crc_ok;
  assign verdict.image_ok     = out_image_ok;
  assign verdict.computed_crc = out_crc;

endmodule
